// File: design/hsl2rgb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared request/response types, angle and percent limits, and the hue ramp
// factor used by the HSL to RGB converter.
// ---------------------------------------------------------------------------
package hsl2rgb_pkg;

    // pipeline depth from input register to output register
    localparam int NUM_STAGES = 7;

    // input limits
    localparam logic [8:0] ANG_60  = 9'd60;
    localparam logic [8:0] ANG_120 = 9'd120;
    localparam logic [8:0] ANG_180 = 9'd180;
    localparam logic [8:0] ANG_240 = 9'd240;
    localparam logic [8:0] ANG_360 = 9'd360;
    localparam logic [8:0] HUE_MAX = ANG_360;
    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam int         NUM_PCT = 101;

    // hue ramp spans 60 degrees
    localparam int unsigned RAMP_STEPS = 60;
    localparam logic [5:0]  RAMP_FULL  = 6'd60;
    localparam logic [5:0]  RAMP_NONE  = 6'd0;

    // largest channel byte
    localparam logic [8:0] BYTE_MAX = 9'd255;

    // one colour request
    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] light_pct;
        logic [7:0] alpha_in;
    } t_hsl_req;

    // one colour result
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_rgb_rsp;

    // per-stage load enables for the channel datapath
    typedef struct packed {
        logic mul;
        logic rcp;
        logic sum;
        logic out;
    } t_chan_en;

    // ramp position in sixtieths: rising, flat top, falling, flat bottom
    function automatic logic [5:0] ramp_factor(input logic [8:0] t);
        logic [8:0] d;
        d = ANG_240 - t;
        if (t < ANG_60) begin
            return t[5:0];
        end else if (t < ANG_180) begin
            return RAMP_FULL;
        end else if (t < ANG_240) begin
            return d[5:0];
        end else begin
            return RAMP_NONE;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/hsl2rgb_chan.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsl2rgb_chan
// One colour channel: scales the q-p span by the ramp factor, divides by 60
// through a reciprocal multiply, adds p and converts the fraction to a byte.
// ---------------------------------------------------------------------------
module hsl2rgb_chan #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire hsl2rgb_pkg::t_chan_en i_en,
    input  wire logic [FRAC_BITS:0]   i_p,
    input  wire logic [FRAC_BITS:0]   i_span,
    input  wire logic [FRAC_BITS:0]   i_lf,
    input  wire logic                 i_grey,
    input  wire logic [5:0]           i_k,
    output logic [7:0]                o_byte
);
    import hsl2rgb_pkg::*;

    localparam int FW    = FRAC_BITS + 1;
    localparam int NW    = FRAC_BITS + 6;
    localparam int MW    = FRAC_BITS + 7;
    localparam int SHIFT = FRAC_BITS + 12;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SHIFT) + 64'(RAMP_STEPS - 1)) / 64'(RAMP_STEPS));

    logic [FW+5:0]    w_span_k;
    logic [NW-1:0]    r_prod;
    logic [FW-1:0]    r_p3;
    logic [FW-1:0]    r_lf3;
    logic             r_grey3;
    logic [NW+MW-1:0] r_scaled;
    logic [FW-1:0]    r_p4;
    logic [FW-1:0]    r_lf4;
    logic             r_grey4;
    logic [FW-1:0]    w_quot;
    logic [FW:0]      w_sum;
    logic [FW-1:0]    n_val;
    logic [FW-1:0]    r_val;
    logic [FW+7:0]    w_x255;
    logic [8:0]       w_c;
    logic [7:0]       n_byte;
    logic [7:0]       r_byte;

    // span times ramp factor, at most 60 * 2^FRAC_BITS
    assign w_span_k = i_span * i_k;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_prod  <= w_span_k[NW-1:0];
            r_p3    <= i_p;
            r_lf3   <= i_lf;
            r_grey3 <= i_grey;
        end
    end

    // exact divide by 60: multiply by rounded-up reciprocal
    always_ff @(posedge i_clk) begin
        if (i_en.rcp) begin
            r_scaled <= r_prod * RECIP;
            r_p4     <= r_p3;
            r_lf4    <= r_lf3;
            r_grey4  <= r_grey3;
        end
    end

    // add p, or take lightness for grey
    assign w_quot = r_scaled[SHIFT +: FW];
    assign w_sum  = {1'b0, r_p4} + {1'b0, w_quot};
    assign n_val  = r_grey4 ? r_lf4 : w_sum[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_val <= n_val;
        end
    end

    // fraction times 255, truncated and clamped
    assign w_x255 = {r_val, 8'd0} - {8'd0, r_val};
    assign w_c    = w_x255[FRAC_BITS +: 9];
    assign n_byte = (w_c > BYTE_MAX) ? BYTE_MAX[7:0] : w_c[7:0];

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule
`default_nettype wire

// File: design/hsl_to_rgb_convert_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsl_to_rgb_convert_top
// Converts an HSL colour with alpha into 8-bit red, green and blue.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall with request i_req (hue in degrees,
// saturation and lightness in percent, alpha). Out-of-range hue and
// percentages saturate. Output channel: o_valid / i_stall with o_rsp.
// A request is taken at a clock edge with valid high and stall low.
// o_valid rises once a taken request reaches the last stage register; while
// o_stall is low one request is accepted every cycle. The seven
// stages are: percent lookup, l*s multiply, q/p and
// hue ramp factors, span multiply, reciprocal multiply for the divide by
// 60, add of p, and conversion to a byte.
// Each stage has its own valid bit and loads when it is empty or the stage
// after it moves, so a stalled receiver fills the bubbles first and o_stall
// rises only once every stage holds a request.
// Reset (i_rst_n low, synchronous) empties the pipeline; data registers are
// not cleared. While i_stall is high the output request is held unchanged.
// ---------------------------------------------------------------------------
module hsl_to_rgb_convert_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire hsl2rgb_pkg::t_hsl_req i_req,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output hsl2rgb_pkg::t_rgb_rsp      o_rsp
);
    import hsl2rgb_pkg::*;

    localparam int FW = FRAC_BITS + 1;
    localparam logic [FW-1:0] FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FW-1:0] FX_HALF = FX_ONE >> 1;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_rdy;
    logic [7:0]            r_alpha [NUM_STAGES];

    logic [FW-1:0] w_frac_tab [NUM_PCT];
    logic [8:0]    n0_hue;
    logic [6:0]    n0_sat;
    logic [6:0]    n0_lit;
    logic [8:0]    r0_hue;
    logic [FW-1:0] r0_sf;
    logic [FW-1:0] r0_lf;

    logic [2*FW-1:0] w_ls;
    logic [FW-1:0]   r1_prod;
    logic [FW-1:0]   r1_sf;
    logic [FW-1:0]   r1_lf;
    logic [8:0]      r1_hue;

    logic [FW:0]   w_q_wide;
    logic [FW-1:0] w_q;
    logic [FW:0]   w_two_l;
    logic [FW:0]   w_p_wide;
    logic [FW-1:0] w_p;
    logic [9:0]    w_t_red_wide;
    logic [8:0]    w_t_red;
    logic [8:0]    w_t_blue;
    logic [5:0]    n2_k [3];
    logic [FW-1:0] r2_p;
    logic [FW-1:0] r2_span;
    logic [FW-1:0] r2_lf;
    logic          r2_grey;
    logic [5:0]    r2_k [3];

    t_chan_en   w_chan_en;
    logic [7:0] w_byte [3];

    // ready chain from the output back to the input
    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // alpha delay line
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_alpha[0] <= i_req.alpha_in;
        end
        for (int s = 1; s < NUM_STAGES; s++) begin
            if (w_rdy[s]) begin
                r_alpha[s] <= r_alpha[s-1];
            end
        end
    end

    // percent to fraction table, pct * 2^FRAC_BITS / 100 truncated
    for (genvar gi = 0; gi < NUM_PCT; gi++) begin : g_frac_tab
        assign w_frac_tab[gi] = FW'((64'(gi) << FRAC_BITS) / 64'd100);
    end

    // stage 0: saturate inputs and look up fractions
    assign n0_hue = (i_req.hue_deg > HUE_MAX) ? HUE_MAX : i_req.hue_deg;
    assign n0_sat = (i_req.sat_pct > PCT_MAX) ? PCT_MAX : i_req.sat_pct;
    assign n0_lit = (i_req.light_pct > PCT_MAX) ? PCT_MAX : i_req.light_pct;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_hue <= n0_hue;
            r0_sf  <= w_frac_tab[n0_sat];
            r0_lf  <= w_frac_tab[n0_lit];
        end
    end

    // stage 1: l * s in fixed point
    assign w_ls = r0_lf * r0_sf;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_prod <= w_ls[FRAC_BITS +: FW];
            r1_sf   <= r0_sf;
            r1_lf   <= r0_lf;
            r1_hue  <= r0_hue;
        end
    end

    // stage 2: q and p, clamped
    always_comb begin
        if (r1_lf < FX_HALF) begin
            w_q_wide = {1'b0, r1_lf} + {1'b0, r1_prod};
        end else begin
            w_q_wide = {1'b0, r1_lf} + {1'b0, r1_sf} - {1'b0, r1_prod};
        end
        w_q      = (w_q_wide > {1'b0, FX_ONE}) ? FX_ONE : w_q_wide[FW-1:0];
        w_two_l  = {r1_lf, 1'b0};
        w_p_wide = (w_two_l < {1'b0, w_q}) ? '0 : (w_two_l - {1'b0, w_q});
        w_p      = (w_p_wide > {1'b0, w_q}) ? w_q : w_p_wide[FW-1:0];
    end

    // stage 2: channel angles wrapped into 0..360, then ramp factors
    assign w_t_red_wide = {1'b0, r1_hue} + {1'b0, ANG_120};
    assign w_t_red      = (w_t_red_wide > {1'b0, ANG_360})
                        ? 9'(w_t_red_wide - {1'b0, ANG_360}) : w_t_red_wide[8:0];
    assign w_t_blue     = (r1_hue < ANG_120) ? (r1_hue + ANG_240) : (r1_hue - ANG_120);

    assign n2_k[0] = ramp_factor(w_t_red);
    assign n2_k[1] = ramp_factor(r1_hue);
    assign n2_k[2] = ramp_factor(w_t_blue);

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_p    <= w_p;
            r2_span <= w_q - w_p;
            r2_lf   <= r1_lf;
            r2_grey <= (r1_sf == '0);
            r2_k    <= n2_k;
        end
    end

    // stages 3 to 6: one datapath per colour channel
    assign w_chan_en.mul = w_rdy[3];
    assign w_chan_en.rcp = w_rdy[4];
    assign w_chan_en.sum = w_rdy[5];
    assign w_chan_en.out = w_rdy[6];

    for (genvar gc = 0; gc < 3; gc++) begin : g_chan
        hsl2rgb_chan #(
            .FRAC_BITS (FRAC_BITS)
        ) u_chan (
            .i_clk  (i_clk),
            .i_en   (w_chan_en),
            .i_p    (r2_p),
            .i_span (r2_span),
            .i_lf   (r2_lf),
            .i_grey (r2_grey),
            .i_k    (r2_k[gc]),
            .o_byte (w_byte[gc])
        );
    end

    assign o_rsp.red_out   = w_byte[0];
    assign o_rsp.green_out = w_byte[1];
    assign o_rsp.blue_out  = w_byte[2];
    assign o_rsp.alpha_out = r_alpha[NUM_STAGES-1];

`ifndef ASSERT_OFF
    // input is held back when every stage is occupied and blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && i_stall) |-> o_stall)
        else $error("stall not raised with a full blocked pipeline");

    // a blocked request in the multiply stage is not dropped
    a_hold_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !w_rdy[1]) |=> r_vld[1])
        else $error("blocked request lost in multiply stage");

    // q never exceeds one
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (({1'b0, r2_p} + {1'b0, r2_span}) <= {1'b0, FX_ONE}))
        else $error("q above one");

    // saturated inputs stay within range
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ((r0_hue <= HUE_MAX) && (r0_sf <= FX_ONE) && (r0_lf <= FX_ONE)))
        else $error("saturated input out of range");
`endif

endmodule
`default_nettype wire

// File: test/tb_hsl_to_rgb_convert_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_hsl_to_rgb_convert_top
// Self-checking bench for the HSL to RGB converter. A short table of colours
// (primaries, greys, hue wrap, out-of-range saturation) is followed by
// random colours. Each accepted request queues its known colour or, lacking
// one, a fixed-point predictor's colour. Every response is checked in
// order against that queue, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module tb_hsl_to_rgb_convert_top;
    import hsl2rgb_pkg::*;

    localparam int          FRAC_BITS   = 16;
    localparam int          NUM_RANDOM  = 1400;
    localparam int          QUIET_TAIL  = 150;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] FX_ONE      = 64'd1 << FRAC_BITS;

    // one row of the colour table: request plus an optional known answer
    typedef struct packed {
        t_hsl_req req;
        logic     known;
        t_rgb_rsp rsp;
    } t_colour_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_hsl_req i_req;
    logic     o_valid;
    logic     i_stall;
    t_rgb_rsp o_rsp;

    t_rgb_rsp    pending_rgb[$];
    t_colour_row colour_table[$];
    t_rgb_rsp    expected_rgb;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          quiet_tail     = 1'b0;

    hsl_to_rgb_convert_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // piecewise hue ramp on whole degrees
    function automatic logic [63:0] ramp_level(input logic [63:0] p, input logic [63:0] q,
                                               input int t);
        logic [63:0] span;
        int          a;
        span = q - p;
        a    = t;
        if (a < 0) a += 360;
        if (a > 360) a -= 360;
        if (a < 60) return p + (span * 64'(a)) / 64'd60;
        if (a < 180) return q;
        if (a < 240) return p + (span * 64'(240 - a)) / 64'd60;
        return p;
    endfunction

    // fraction to byte, truncated and clamped
    function automatic logic [7:0] level_to_byte(input logic [63:0] v);
        logic [63:0] c;
        c = (v * 64'd255) >> FRAC_BITS;
        return (c > 64'd255) ? 8'd255 : c[7:0];
    endfunction

    // expected colour for one request
    function automatic t_rgb_rsp predict_rgb(input t_hsl_req req);
        logic [63:0] hue, sat, lit, sf, lf, q, p, prod, r, g, b;
        longint      p_wide;
        t_rgb_rsp    rsp;
        hue = (req.hue_deg > HUE_MAX) ? 64'(HUE_MAX) : 64'(req.hue_deg);
        sat = (req.sat_pct > PCT_MAX) ? 64'(PCT_MAX) : 64'(req.sat_pct);
        lit = (req.light_pct > PCT_MAX) ? 64'(PCT_MAX) : 64'(req.light_pct);
        sf  = (sat * FX_ONE) / 64'd100;
        lf  = (lit * FX_ONE) / 64'd100;
        if (sf == 64'd0) begin
            r = lf;
            g = lf;
            b = lf;
        end else begin
            prod = (lf * sf) >> FRAC_BITS;
            if (lf < (FX_ONE >> 1)) begin
                q = lf + prod;
            end else begin
                q = lf + sf - prod;
            end
            if (q > FX_ONE) q = FX_ONE;
            p_wide = $signed(2 * lf) - $signed(q);
            if (p_wide < 0) p_wide = 0;
            if (64'(p_wide) > q) p_wide = $signed(q);
            p = 64'(p_wide);
            r = ramp_level(p, q, int'(hue) + 120);
            g = ramp_level(p, q, int'(hue));
            b = ramp_level(p, q, int'(hue) - 120);
        end
        rsp.red_out   = level_to_byte(r);
        rsp.green_out = level_to_byte(g);
        rsp.blue_out  = level_to_byte(b);
        rsp.alpha_out = req.alpha_in;
        return rsp;
    endfunction

    function automatic t_colour_row colour_row(input int hue, input int sat, input int lit,
                                               input int alpha, input bit known,
                                               input int r, input int g, input int b);
        t_colour_row row;
        row.req.hue_deg   = 9'(hue);
        row.req.sat_pct   = 7'(sat);
        row.req.light_pct = 7'(lit);
        row.req.alpha_in  = 8'(alpha);
        row.known         = known;
        row.rsp.red_out   = 8'(r);
        row.rsp.green_out = 8'(g);
        row.rsp.blue_out  = 8'(b);
        row.rsp.alpha_out = 8'(alpha);
        return row;
    endfunction

    // append one row to the colour table
    task automatic add_colour(input t_colour_row row);
        colour_table = {colour_table, row};
    endtask

    // present one request and hold it until taken
    task automatic send_colour(input t_colour_row row);
        i_valid <= 1'b1;
        i_req   <= row.req;
        do @(posedge i_clk); while (o_stall);
        pending_rgb = {pending_rgb, (row.known ? row.rsp : predict_rgb(row.req))};
    endtask

    task automatic log_failure(input string what, input t_rgb_rsp want, input t_rgb_rsp got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                     what, want.red_out, want.green_out, want.blue_out, want.alpha_out,
                     got.red_out, got.green_out, got.blue_out, got.alpha_out);
        end
    endtask

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rgb.size() == 0) begin
                log_failure("unexpected response", '0, o_rsp);
            end else begin
                expected_rgb = pending_rgb.pop_front();
                if (o_rsp.red_out !== expected_rgb.red_out
                        || o_rsp.green_out !== expected_rgb.green_out
                        || o_rsp.blue_out !== expected_rgb.blue_out
                        || o_rsp.alpha_out !== expected_rgb.alpha_out) begin
                    log_failure("colour mismatch", expected_rgb, o_rsp);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    initial begin
        int stall_pct;
        stall_pct = 10;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 8;
                    default: stall_pct = 30;
                endcase
            end
            if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // stimulus
    initial begin
        t_colour_row row;
        int          gap_pct;
        int          num_items;
        bit          pause_now;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_req   <= '0;
        gap_pct = 10;

        // colour table: known answers for greys, primaries and limits
        add_colour(colour_row(  0,   0,   0,   0, 1,   0,   0,   0));
        add_colour(colour_row(  0,   0, 100, 255, 1, 255, 255, 255));
        add_colour(colour_row(180,   0,  50,  90, 1, 127, 127, 127));
        add_colour(colour_row(  0, 100, 100, 165, 1, 255, 255, 255));
        add_colour(colour_row(  0, 100,   0,   1, 1,   0,   0,   0));
        add_colour(colour_row(  0, 100,  50, 128, 1, 255,   0,   0));
        add_colour(colour_row(120, 100,  50, 127, 1,   0, 255,   0));
        add_colour(colour_row(240, 100,  50, 254, 1,   0,   0, 255));
        add_colour(colour_row(360, 100,  50,  51, 1, 255,   0,   0));
        add_colour(colour_row(511, 127,  50, 204, 1, 255,   0,   0));
        add_colour(colour_row(300,   0, 127,  16, 1, 255, 255, 255));
        add_colour(colour_row(127, 127, 127, 255, 1, 255, 255, 255));
        // ramp edges and mixed colours, checked against the predictor
        add_colour(colour_row( 60, 100,  50,  60, 0, 0, 0, 0));
        add_colour(colour_row(180, 100,  50, 180, 0, 0, 0, 0));
        add_colour(colour_row(300, 100,  50,  44, 0, 0, 0, 0));
        add_colour(colour_row( 59, 100,  50,  59, 0, 0, 0, 0));
        add_colour(colour_row( 61, 100,  50,  61, 0, 0, 0, 0));
        add_colour(colour_row(239, 100,  50, 239, 0, 0, 0, 0));
        add_colour(colour_row(  1,   1,  49,   2, 0, 0, 0, 0));
        add_colour(colour_row(359,  99,  51,   3, 0, 0, 0, 0));
        add_colour(colour_row(256,  64,  64,  85, 0, 0, 0, 0));
        add_colour(colour_row( 30,  50,  25, 170, 0, 0, 0, 0));
        add_colour(colour_row(210,  75,  80,  15, 0, 0, 0, 0));
        add_colour(colour_row(100, 127,   1, 240, 0, 0, 0, 0));
        add_colour(colour_row(361,  50,  50,   7, 0, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        num_items = colour_table.size() + NUM_RANDOM;
        for (int i = 0; i < num_items; i++) begin
            if (i < colour_table.size()) begin
                row = colour_table[i];
            end else begin
                row.known = 1'b0;
                row.rsp   = '0;
                // hue: mostly in range, some near ramp corners, some raw
                case ($urandom_range(0, 7))
                    0: row.req.hue_deg = 9'($urandom);
                    1: row.req.hue_deg = 9'(60 * $urandom_range(0, 6) + $urandom_range(0, 1));
                    2: row.req.hue_deg = 9'(60 * $urandom_range(1, 6) - 1);
                    default: row.req.hue_deg = 9'($urandom_range(0, 360));
                endcase
                case ($urandom_range(0, 7))
                    0: row.req.sat_pct = 7'($urandom);
                    1: row.req.sat_pct = 7'd0;
                    2: row.req.sat_pct = PCT_MAX;
                    default: row.req.sat_pct = 7'($urandom_range(0, 100));
                endcase
                case ($urandom_range(0, 7))
                    0: row.req.light_pct = 7'($urandom);
                    1: row.req.light_pct = 7'(48 + $urandom_range(0, 4));
                    2: row.req.light_pct = $urandom_range(0, 1) ? PCT_MAX : 7'd0;
                    default: row.req.light_pct = 7'($urandom_range(0, 100));
                endcase
                row.req.alpha_in = 8'($urandom);
            end
            quiet_tail = (i >= num_items - QUIET_TAIL);
            send_colour(row);

            // sender idling, plus one drain of the pipeline mid-run
            pause_now = (i == colour_table.size() + NUM_RANDOM / 2);
            if ($urandom_range(0, 49) == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
            end
            if (pause_now || (!quiet_tail && $urandom_range(0, 99) < gap_pct)) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                while (pause_now && pending_rgb.size() != 0) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // drain, then allow a little extra for stray responses
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (NUM_STAGES + 5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
